### src/rvf_pkg.sv
`timescale 1ns / 1ps
package rvf_pkg;

  // widths fixed by the pixel and coefficient formats
  localparam int SAMPLE_W = 16;
  localparam int COEFF_W  = 16;
  localparam int SUM_W    = 32;
  localparam int COL_W    = 12;
  localparam int LANES    = 8;

  typedef logic signed [SUM_W-1:0] prod_t;

  // register indexes of the config port
  typedef enum logic [2:0] {
    CFG_COEFF_LO  = 3'd0,
    CFG_COEFF_HI  = 3'd1,
    CFG_TAP_COUNT = 3'd2,
    CFG_PASS_MODE = 3'd3,
    CFG_PIXEL_MAX = 3'd4
  } cfg_reg_t;

  // pass modes
  typedef enum logic [1:0] {
    PASS_SINGLE  = 2'd0,
    PASS_INITIAL = 2'd1,
    PASS_UPDATE  = 2'd2,
    PASS_FINAL   = 2'd3
  } pass_mode_t;

endpackage

### src/rvf_if.sv
`timescale 1ns / 1ps
// column channel: one column of eight source pixels
interface rvf_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] column;
  logic [15:0] sample_0;
  logic [15:0] sample_1;
  logic [15:0] sample_2;
  logic [15:0] sample_3;
  logic [15:0] sample_4;
  logic [15:0] sample_5;
  logic [15:0] sample_6;
  logic [15:0] sample_7;

  modport source (
    output valid, column, sample_0, sample_1, sample_2, sample_3,
           sample_4, sample_5, sample_6, sample_7,
    input  ready
  );
  modport sink (
    input  valid, column, sample_0, sample_1, sample_2, sample_3,
           sample_4, sample_5, sample_6, sample_7,
    output ready
  );
endinterface

// pixel channel: one filtered pixel
interface rvf_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] out_column;
  logic [15:0] pixel;

  modport source (output valid, out_column, pixel, input ready);
  modport sink (input valid, out_column, pixel, output ready);
endinterface

### src/resize_vertical_u16_fir_accum.sv
`timescale 1ns / 1ps
// vertical fir pass of an image resampler on 16-bit pixels
// cols channel: one item is a column of eight source pixels (one per tap)
// plus its column position; pixels channel: one filtered pixel per item in
// single and final passes, nothing in initial and update passes
// config port: cfg_we / cfg_index / cfg_data, write only, taken at once;
// change it only while the pipe is empty
// throughput: one column per cycle unless pixels.ready holds the pipe, set by
// the eight parallel multiplier lanes and the partial sum ram (one read and
// one write port per cycle); a pixel's path after its column is accepted:
// lane multiply on the accepting edge, then merge, sum add, total, output reg
// partial sums: LINE_WIDTH words of 32 bits in ram, not cleared; an update
// or final pass must follow an initial pass on the same column
// a column whose partial sum is written by the item directly ahead of it
// gets the new value through a bypass
// stall: when pixels.ready is low the output register holds its item and
// the stages behind it keep filling; cols.ready drops only once every
// stage holds an item
// reset: all stages empty, registers to defaults (coefficients zero, eight
// taps, single pass, pixel max 65535)
module resize_vertical_u16_fir_accum #(
  parameter int LINE_WIDTH = 4096
) (
  input  logic             clk,
  input  logic             rst,
  rvf_in_if.sink           cols,
  rvf_out_if.source        pixels,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [63:0]      cfg_data
);

  localparam int AW = $clog2(LINE_WIDTH);
  localparam logic [16:0] LINE_LIMIT = 17'(LINE_WIDTH);

  // register indexes
  localparam logic [2:0] CFG_COEFF_LO  = rvf_pkg::CFG_COEFF_LO;
  localparam logic [2:0] CFG_COEFF_HI  = rvf_pkg::CFG_COEFF_HI;
  localparam logic [2:0] CFG_TAP_COUNT = rvf_pkg::CFG_TAP_COUNT;
  localparam logic [2:0] CFG_PASS_MODE = rvf_pkg::CFG_PASS_MODE;
  localparam logic [2:0] CFG_PIXEL_MAX = rvf_pkg::CFG_PIXEL_MAX;

  // pass modes
  localparam logic [1:0] PASS_SINGLE  = rvf_pkg::PASS_SINGLE;
  localparam logic [1:0] PASS_INITIAL = rvf_pkg::PASS_INITIAL;
  localparam logic [1:0] PASS_UPDATE  = rvf_pkg::PASS_UPDATE;
  localparam logic [1:0] PASS_FINAL   = rvf_pkg::PASS_FINAL;

  localparam logic signed [31:0] ROUND_ADD = 32'sd8192;
  localparam int                 Q_SHIFT   = 14;
  localparam logic signed [31:0] SAT_HI    = 32'sd32767;
  localparam logic signed [31:0] SAT_LO    = -32'sd32768;

  // what an item does with the partial sum store and the output
  typedef struct packed {
    logic rd;
    logic wr;
    logic emit;
  } item_flags_t;

  // configuration registers
  logic [63:0] coeff_low_four;
  logic [63:0] coeff_high_four;
  logic [3:0]  tap_count;
  logic [1:0]  pass_mode;
  logic [15:0] pixel_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_low_four  <= '0;
      coeff_high_four <= '0;
      tap_count       <= 4'd8;
      pass_mode       <= PASS_SINGLE;
      pixel_max       <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COEFF_LO:  coeff_low_four  <= cfg_data;
        CFG_COEFF_HI:  coeff_high_four <= cfg_data;
        CFG_TAP_COUNT: tap_count       <= cfg_data[3:0];
        CFG_PASS_MODE: pass_mode       <= cfg_data[1:0];
        CFG_PIXEL_MAX: pixel_max       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // stage valids, ready chain from the output back
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic ld1, ld2, ld3, ld4, ld5;
  item_flags_t f1, f2, f3;
  logic [rvf_pkg::COL_W-1:0] c1, c2, c3, c4;

  assign rdy5 = !v5 || pixels.ready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || !f3.emit || rdy4;   // partial passes leave at once
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign ld1 = cols.valid && rdy1;
  assign ld2 = v1 && rdy2;
  assign ld3 = v2 && rdy3;
  assign ld4 = v3 && f3.emit && rdy4;
  assign ld5 = v4 && rdy5;

  assign cols.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= cols.valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3 && f3.emit;
      end
      if (rdy5) begin
        v5 <= v4;
      end
    end
  end

  // accept side: decode the pass into per-item flags and lane enables
  logic                            partial_pass;
  logic                            in_store;
  item_flags_t                     f_in;
  logic [rvf_pkg::LANES-1:0]       lane_on;
  logic [rvf_pkg::SAMPLE_W-1:0]    samples [rvf_pkg::LANES];
  logic signed [rvf_pkg::COEFF_W-1:0] coeffs [rvf_pkg::LANES];
  rvf_pkg::prod_t                  prods [rvf_pkg::LANES];

  assign partial_pass = (pass_mode == PASS_INITIAL) || (pass_mode == PASS_UPDATE);
  assign in_store     = {5'd0, cols.column} < LINE_LIMIT;
  assign f_in.rd      = ((pass_mode == PASS_UPDATE) || (pass_mode == PASS_FINAL)) && in_store;
  assign f_in.wr      = partial_pass && in_store;
  assign f_in.emit    = !partial_pass;

  assign samples[0] = cols.sample_0;
  assign samples[1] = cols.sample_1;
  assign samples[2] = cols.sample_2;
  assign samples[3] = cols.sample_3;
  assign samples[4] = cols.sample_4;
  assign samples[5] = cols.sample_5;
  assign samples[6] = cols.sample_6;
  assign samples[7] = cols.sample_7;

  for (genvar k = 0; k < rvf_pkg::LANES; k++) begin : g_lane
    // partial passes use all taps; otherwise the first tap_count
    assign lane_on[k] = partial_pass || (4'(k) < tap_count);
    if (k < 4) begin : g_lo
      assign coeffs[k] = coeff_low_four[16*k +: 16];
    end else begin : g_hi
      assign coeffs[k] = coeff_high_four[16*(k-4) +: 16];
    end
    rvf_lane u_lane (
      .clk    (clk),
      .load   (ld1),
      .active (lane_on[k]),
      .sample (samples[k]),
      .coeff  (coeffs[k]),
      .prod   (prods[k])
    );
  end

  rvf_pkg::prod_t psum2;

  rvf_merge u_merge (
    .clk   (clk),
    .load  (ld2),
    .prods (prods),
    .psum  (psum2)
  );

  // item tags ride along with the data
  always_ff @(posedge clk) begin
    if (ld1) begin
      c1 <= cols.column;
      f1 <= f_in;
    end
    if (ld2) begin
      c2 <= c1;
      f2 <= f1;
    end
  end

  // partial sum store and accumulate stage
  logic [AW+rvf_pkg::COL_W-1:0] c2_ext, c3_ext;
  logic [AW-1:0]                ram_raddr, ram_waddr;
  logic                         ram_re, ram_we;
  logic [31:0]                  ram_rdata;
  rvf_pkg::prod_t               psum3;
  logic                         s3_fwd;
  logic [31:0]                  s3_fwd_data;
  logic [31:0]                  stored3;
  logic [31:0]                  total3;
  logic [31:0]                  total4;

  assign c2_ext    = {{AW{1'b0}}, c2};
  assign c3_ext    = {{AW{1'b0}}, c3};
  assign ram_raddr = c2_ext[AW-1:0];
  assign ram_waddr = c3_ext[AW-1:0];
  assign ram_re    = ld3;
  assign ram_we    = v3 && f3.wr && rdy3;

  rvf_ram #(
    .WIDTH (32),
    .DEPTH (LINE_WIDTH)
  ) u_psum_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (total3),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // the ram read misses a write on the same edge, so bypass it
  assign stored3 = !f3.rd ? 32'd0 : (s3_fwd ? s3_fwd_data : ram_rdata);
  assign total3  = stored3 + 32'(psum3);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_fwd <= 1'b0;
    end else if (ld3) begin
      s3_fwd <= ram_we && (ram_waddr == ram_raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      c3          <= c2;
      f3          <= f2;
      psum3       <= psum2;
      s3_fwd_data <= total3;
    end
    if (ld4) begin
      c4     <= c3;
      total4 <= total3;
    end
  end

  // round, shift, saturate to int16, cap at the pixel maximum, unbias
  logic signed [31:0] rounded;
  logic signed [31:0] shifted;
  logic signed [15:0] sat;
  logic signed [15:0] cap;
  logic signed [15:0] capped;

  always_comb begin
    rounded = $signed(total4) + ROUND_ADD;
    shifted = rounded >>> Q_SHIFT;
    if (shifted > SAT_HI) begin
      sat = 16'(SAT_HI);
    end else if (shifted < SAT_LO) begin
      sat = 16'(SAT_LO);
    end else begin
      sat = shifted[15:0];
    end
    cap    = $signed({~pixel_max[15], pixel_max[14:0]});
    capped = (sat > cap) ? cap : sat;
  end

  always_ff @(posedge clk) begin
    if (ld5) begin
      pixels.out_column <= c4;
      pixels.pixel      <= {~capped[15], capped[14:0]};
    end
  end

  assign pixels.valid = v5;

`ifndef ASSERT_OFF
  // the bypass is armed exactly when a write hit the address being read
  a_bypass: assert property (@(posedge clk) disable iff (rst)
    ram_re |=> (s3_fwd == $past(ram_we && (ram_waddr == ram_raddr))))
    else $error("partial sum bypass flag wrong");

  // a read always belongs to an item entering the accumulate stage
  a_read_stage: assert property (@(posedge clk) disable iff (rst)
    ram_re |=> v3)
    else $error("ram read without item in accumulate stage");

  // an output comes only from an item that sat in the total stage
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(pixels.valid) |-> $past(v4))
    else $error("output valid without a producing item");

  // reset empties the whole pipe
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!v1 && !v2 && !v3 && !v4 && !pixels.valid))
    else $error("pipeline not empty after reset");
`endif

endmodule

### src/rvf_ram.sv
`timescale 1ns / 1ps
module rvf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/rvf_lane.sv
`timescale 1ns / 1ps
module rvf_lane (
  input  logic                                  clk,
  input  logic                                  load,
  input  logic                                  active,
  input  logic [rvf_pkg::SAMPLE_W-1:0]          sample,
  input  logic signed [rvf_pkg::COEFF_W-1:0]    coeff,
  output rvf_pkg::prod_t                        prod
);

  logic signed [rvf_pkg::SAMPLE_W-1:0] biased;
  rvf_pkg::prod_t                      mul;

  // sample minus 32768 is the sample with its top bit flipped
  assign biased = {~sample[rvf_pkg::SAMPLE_W-1], sample[rvf_pkg::SAMPLE_W-2:0]};
  assign mul    = biased * coeff;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= active ? mul : '0;
    end
  end

endmodule

### src/rvf_merge.sv
`timescale 1ns / 1ps
module rvf_merge (
  input  logic           clk,
  input  logic           load,
  input  rvf_pkg::prod_t prods [rvf_pkg::LANES],
  output rvf_pkg::prod_t psum
);

  rvf_pkg::prod_t tree_sum;

  // wrapping sum of all lane products
  always_comb begin
    tree_sum = '0;
    for (int k = 0; k < rvf_pkg::LANES; k++) begin
      tree_sum = tree_sum + prods[k];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      psum <= tree_sum;
    end
  end

endmodule

### verif/resize_vertical_u16_fir_accum_tb.sv
`timescale 1ns / 1ps
module resize_vertical_u16_fir_accum_tb;

  // one column item and one pixel item
  typedef struct packed {
    logic [rvf_pkg::COL_W-1:0]                         col;
    logic [rvf_pkg::LANES-1:0][rvf_pkg::SAMPLE_W-1:0]  s;
  } column_t;

  typedef struct packed {
    logic [rvf_pkg::COL_W-1:0]    col;
    logic [rvf_pkg::SAMPLE_W-1:0] pix;
  } pixel_t;

  localparam int LINE_WIDTH   = 4096;
  localparam int RANDOM_ITEMS = 1300;
  // leave a margin for the pipe to drain before touching config
  localparam int DRAIN_CYCLES = 12;
  // worst case covers the random gaps and hold-offs per item plus config and drain pauses
  localparam int MAX_CYCLES   = 400000;

  // predicts the filtered pixels and keeps the per-column partial sums
  class vfilter_scoreboard;
    logic [63:0]                coeff_lo;
    logic [63:0]                coeff_hi;
    logic [3:0]                 taps;
    rvf_pkg::pass_mode_t        mode;
    logic [15:0]                pmax;
    logic [rvf_pkg::SUM_W-1:0]  psum [LINE_WIDTH];
    pixel_t                     expected_pixels [$];
    int                         errors;
    int                         n_columns;
    int                         n_pixels;
    int                         n_stored;

    function new();
      coeff_lo  = '0;
      coeff_hi  = '0;
      taps      = 4'd8;
      mode      = rvf_pkg::PASS_SINGLE;
      pmax      = 16'hFFFF;
      errors    = 0;
      n_columns = 0;
      n_pixels  = 0;
      n_stored  = 0;
      foreach (psum[i]) psum[i] = '0;
    endfunction

    function void set_reg(rvf_pkg::cfg_reg_t idx, logic [63:0] d);
      case (idx)
        rvf_pkg::CFG_COEFF_LO:  coeff_lo = d;
        rvf_pkg::CFG_COEFF_HI:  coeff_hi = d;
        rvf_pkg::CFG_TAP_COUNT: taps = d[3:0];
        rvf_pkg::CFG_PASS_MODE: mode = rvf_pkg::pass_mode_t'(d[1:0]);
        rvf_pkg::CFG_PIXEL_MAX: pmax = d[15:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    // accepted column: accumulate, then store the sum or predict a pixel
    function void note_column(column_t c);
      logic [rvf_pkg::SUM_W-1:0] acc;
      logic [rvf_pkg::SUM_W-1:0] rounded;
      int               n;
      int               w;
      int               x;
      int               r;
      int               cap;
      pixel_t           want;
      n_columns++;
      if (mode == rvf_pkg::PASS_INITIAL || mode == rvf_pkg::PASS_UPDATE)
        n = rvf_pkg::LANES;
      else
        n = (taps > 4'd8) ? rvf_pkg::LANES : int'(taps);
      acc = (mode == rvf_pkg::PASS_UPDATE || mode == rvf_pkg::PASS_FINAL) ? psum[c.col] : '0;
      for (int k = 0; k < n; k++) begin
        if (k < 4)
          w = int'($signed(coeff_lo[16*k +: 16]));
        else
          w = int'($signed(coeff_hi[16*(k-4) +: 16]));
        x = int'(c.s[k]) - 32768;
        acc = acc + rvf_pkg::SUM_W'(w * x);
      end
      if (mode == rvf_pkg::PASS_INITIAL || mode == rvf_pkg::PASS_UPDATE) begin
        psum[c.col] = acc;
        n_stored++;
        return;
      end
      // round, arithmetic shift, saturate, cap, remove the bias
      rounded = acc + 32'd8192;
      r = int'($signed(rounded)) >>> 14;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      cap = int'($signed(pmax ^ 16'h8000));
      if (r > cap) r = cap;
      want.col = c.col;
      want.pix = 16'(r + 32768);
      expected_pixels.push_back(want);
    endfunction

    function void match_pixel(logic [rvf_pkg::COL_W-1:0] col,
                              logic [rvf_pkg::SAMPLE_W-1:0] pix);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel: expected none, actual column %0d pixel %0d",
                 $time, col, pix);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      n_pixels++;
      if (col !== want.col) begin
        $display("%0t: out_column mismatch: expected %0d, actual %0d",
                 $time, want.col, col);
        errors++;
      end
      if (pix !== want.pix) begin
        $display("%0t: pixel mismatch at column %0d: expected %0d, actual %0d",
                 $time, want.col, want.pix, pix);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  rvf_in_if  cols_ch ();
  rvf_out_if pixels_ch ();

  resize_vertical_u16_fir_accum #(
    .LINE_WIDTH(LINE_WIDTH)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cols      (cols_ch),
    .pixels    (pixels_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  vfilter_scoreboard sb;

  // stimulus state
  bit                        src_steady;
  bit                        sink_steady;
  int                        items_sent;
  int                        n_settings;
  int                        cycle_count;
  logic [rvf_pkg::COL_W-1:0] run_cols [$];
  logic [rvf_pkg::COL_W-1:0] seen_cols [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("resize_vertical_u16_fir_accum regression: fail");
      $finish;
    end
  end

  // pixel receiver: random hold-off per item, or steady ready in some phases
  initial begin
    int hold;
    forever begin
      hold = sink_steady ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        pixels_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      pixels_ch.ready <= 1'b1;
      // values read right after the edge are the ones the edge sampled
      do @(posedge clk); while (rst || !pixels_ch.valid);
    end
  end

  // every accepted pixel goes to the checker
  always @(posedge clk) begin
    if (!rst && pixels_ch.valid && pixels_ch.ready)
      sb.match_pixel(pixels_ch.out_column, pixels_ch.pixel);
  end

  // ---------------------------------------------------------------------------
  // random field helpers
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      default: return 16'h7FFF;
    endcase
  endfunction

  // q14 coefficient: extremes, anything, or a plausible kernel weight
  function automatic logic [15:0] pick_coeff();
    case ($urandom_range(0, 5))
      0: return pick_extreme();
      1, 2: return 16'($urandom);
      default: return 16'($urandom_range(0, 20480)) - 16'd2048;
    endcase
  endfunction

  function automatic logic [63:0] rand_coeffs();
    logic [63:0] w;
    for (int k = 0; k < 4; k++) w[16*k +: 16] = pick_coeff();
    return w;
  endfunction

  // pixel: extremes, full range, or bounded by a random bit depth
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return pick_extreme();
      1, 2, 3, 4: return 16'($urandom);
      default: return 16'($urandom_range(0, (1 << $urandom_range(1, 16)) - 1));
    endcase
  endfunction

  function automatic column_t rand_column(logic [rvf_pkg::COL_W-1:0] col);
    column_t c;
    c.col = col;
    for (int k = 0; k < rvf_pkg::LANES; k++) c.s[k] = pick_sample();
    return c;
  endfunction

  function automatic column_t flat_column(logic [rvf_pkg::COL_W-1:0] col, logic [15:0] v);
    column_t c;
    c.col = col;
    for (int k = 0; k < rvf_pkg::LANES; k++) c.s[k] = v;
    return c;
  endfunction

  // tap count: mostly legal, sometimes zero or above eight
  function automatic logic [3:0] rand_taps();
    case ($urandom_range(0, 9))
      0: return 4'($urandom_range(9, 15));
      1: return 4'd0;
      default: return 4'($urandom_range(1, 8));
    endcase
  endfunction

  // pixel max: usually two to the depth minus one, sometimes odd or zero
  function automatic logic [15:0] rand_pmax();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1, 2: return 16'($urandom_range(0, 65535));
      default: return 16'((1 << $urandom_range(1, 16)) - 1);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // write enable stays high across back-to-back writes; caller lowers it
  task automatic write_reg(input rvf_pkg::cfg_reg_t idx, input logic [63:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    sb.set_reg(idx, d);
  endtask

  task automatic load_setting(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [3:0] nt, input rvf_pkg::pass_mode_t pm,
                              input logic [15:0] mx);
    write_reg(rvf_pkg::CFG_COEFF_LO, lo);
    write_reg(rvf_pkg::CFG_COEFF_HI, hi);
    write_reg(rvf_pkg::CFG_TAP_COUNT, 64'(nt));
    write_reg(rvf_pkg::CFG_PASS_MODE, 64'(pm));
    write_reg(rvf_pkg::CFG_PIXEL_MAX, 64'(mx));
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // block idle: all pixels back, then enough cycles for a store to land
  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one column item; valid stays high across back-to-back items
  task automatic send_column(input column_t c);
    int gap;
    bit drain;
    gap   = src_steady ? 0 : $urandom_range(0, 9);
    // now and then hold off until the pipe has emptied
    drain = (items_sent == 10) || ($urandom_range(0, 63) == 0);
    if (drain && gap == 0) gap = 1;
    if (gap > 0) begin
      cols_ch.valid <= 1'b0;
      if (drain) while (sb.pending() != 0) @(posedge clk);
      repeat (gap) @(posedge clk);
    end
    cols_ch.valid    <= 1'b1;
    cols_ch.column   <= c.col;
    cols_ch.sample_0 <= c.s[0];
    cols_ch.sample_1 <= c.s[1];
    cols_ch.sample_2 <= c.s[2];
    cols_ch.sample_3 <= c.s[3];
    cols_ch.sample_4 <= c.s[4];
    cols_ch.sample_5 <= c.s[5];
    cols_ch.sample_6 <= c.s[6];
    cols_ch.sample_7 <= c.s[7];
    do @(posedge clk); while (!cols_ch.ready);
    sb.note_column(c);
    if (sb.mode == rvf_pkg::PASS_INITIAL) seen_cols.push_back(c.col);
    items_sent++;
  endtask

  // one pass over run_cols with random pixels, starting at a random point
  task automatic send_pass();
    int n;
    int first;
    n     = run_cols.size();
    first = $urandom_range(0, n - 1);
    for (int k = 0; k < n; k++) send_column(rand_column(run_cols[(first + k) % n]));
    cols_ch.valid <= 1'b0;
  endtask

  // single pass over random columns
  task automatic run_single_batch();
    int n;
    n = $urandom_range(20, 60);
    load_setting(rand_coeffs(), rand_coeffs(), rand_taps(), rvf_pkg::PASS_SINGLE,
                 rand_pmax());
    for (int k = 0; k < n; k++) send_column(rand_column(rvf_pkg::COL_W'($urandom)));
    cols_ch.valid <= 1'b0;
  endtask

  // wider filter: initial pass, a few updates, then the final pass, each
  // with its own coefficient slice, over a run of mostly adjacent columns
  task automatic run_wide_filter();
    int                        n;
    int                        ups;
    logic [rvf_pkg::COL_W-1:0] base;
    n    = $urandom_range(4, 40);
    base = rvf_pkg::COL_W'($urandom);
    run_cols.delete();
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 5) == 0)
        run_cols.push_back(rvf_pkg::COL_W'($urandom));
      else
        run_cols.push_back(base + rvf_pkg::COL_W'(k));
    end
    load_setting(rand_coeffs(), rand_coeffs(), rand_taps(), rvf_pkg::PASS_INITIAL,
                 rand_pmax());
    send_pass();
    ups = $urandom_range(0, 3);
    repeat (ups) begin
      settle();
      load_setting(rand_coeffs(), rand_coeffs(), rand_taps(), rvf_pkg::PASS_UPDATE,
                   rand_pmax());
      send_pass();
    end
    settle();
    load_setting(rand_coeffs(), rand_coeffs(), rand_taps(), rvf_pkg::PASS_FINAL,
                 rand_pmax());
    send_pass();
  endtask

  // out-of-order passes: any mode, but reads only hit columns stored before
  task automatic run_broken_sequence();
    int                  n;
    rvf_pkg::pass_mode_t pm;
    pm = rvf_pkg::pass_mode_t'($urandom_range(0, 3));
    if (seen_cols.size() == 0 &&
        (pm == rvf_pkg::PASS_UPDATE || pm == rvf_pkg::PASS_FINAL))
      pm = rvf_pkg::PASS_INITIAL;
    n = $urandom_range(4, 24);
    run_cols.delete();
    for (int k = 0; k < n; k++) begin
      if (pm == rvf_pkg::PASS_UPDATE || pm == rvf_pkg::PASS_FINAL)
        run_cols.push_back(seen_cols[$urandom_range(0, seen_cols.size() - 1)]);
      else
        run_cols.push_back(rvf_pkg::COL_W'($urandom));
    end
    load_setting(rand_coeffs(), rand_coeffs(), rand_taps(), pm, rand_pmax());
    send_pass();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    column_t c;
    int      pick;
    sb          = new();
    src_steady  = 1'b0;
    sink_steady = 1'b0;
    items_sent  = 0;
    n_settings  = 0;

    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= rvf_pkg::CFG_COEFF_LO;
    cfg_data         <= '0;
    cols_ch.valid    <= 1'b0;
    cols_ch.column   <= '0;
    cols_ch.sample_0 <= '0;
    cols_ch.sample_1 <= '0;
    cols_ch.sample_2 <= '0;
    cols_ch.sample_3 <= '0;
    cols_ch.sample_4 <= '0;
    cols_ch.sample_5 <= '0;
    cols_ch.sample_6 <= '0;
    cols_ch.sample_7 <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extreme coefficients, full eight taps, pixels at the range ends
    load_setting({16'hFFFF, 16'h7FFF, 16'h8000, 16'h4000},
                 {16'h2000, 16'hC000, 16'h0000, 16'h0001},
                 4'd8, rvf_pkg::PASS_SINGLE, 16'hFFFF);
    send_column(flat_column(12'd0, 16'h0000));
    send_column(flat_column(12'd4095, 16'hFFFF));
    c = flat_column(12'd1, 16'h0000);
    for (int k = 1; k < rvf_pkg::LANES; k += 2) c.s[k] = 16'hFFFF;
    send_column(c);
    send_column(flat_column(12'd2, 16'h8000));
    send_column(flat_column(12'd3, 16'h7FFF));
    cols_ch.valid <= 1'b0;

    // no taps at all: output is the rounded zero
    settle();
    load_setting({4{16'h4000}}, {4{16'h4000}}, 4'd0, rvf_pkg::PASS_SINGLE, 16'hFFFF);
    send_column(flat_column(12'd5, 16'hFFFF));
    cols_ch.valid <= 1'b0;

    // tap count above eight acts as eight; cap at a 10-bit maximum
    settle();
    load_setting({4{16'h7FFF}}, {4{16'h7FFF}}, 4'd15, rvf_pkg::PASS_SINGLE, 16'd1023);
    send_column(flat_column(12'd6, 16'hFFFF));
    cols_ch.valid <= 1'b0;

    // pixel max zero forces the output to zero
    settle();
    load_setting({4{16'h4000}}, '0, 4'd1, rvf_pkg::PASS_SINGLE, 16'd0);
    send_column(flat_column(12'd8, 16'hFFFF));
    cols_ch.valid <= 1'b0;

    // partial sums at both ends of the line and in between
    settle();
    load_setting({4{16'h1000}}, {4{16'hF000}}, 4'd8, rvf_pkg::PASS_INITIAL, 16'hFFFF);
    send_column(flat_column(12'd0, 16'hFFFF));
    send_column(flat_column(12'd4095, 16'h0000));
    send_column(flat_column(12'd7, 16'h8001));
    cols_ch.valid <= 1'b0;
    settle();
    load_setting({4{16'h8000}}, {4{16'h7FFF}}, 4'd8, rvf_pkg::PASS_UPDATE, 16'hFFFF);
    send_column(flat_column(12'd0, 16'h0000));
    send_column(flat_column(12'd4095, 16'hFFFF));
    cols_ch.valid <= 1'b0;
    settle();
    load_setting({4{16'h2000}}, {4{16'hE000}}, 4'd3, rvf_pkg::PASS_FINAL, 16'd4095);
    send_column(flat_column(12'd0, 16'hFFFF));
    send_column(flat_column(12'd4095, 16'h0000));
    send_column(flat_column(12'd7, 16'h1234));
    cols_ch.valid <= 1'b0;
    // final pass with no taps: the stored sum alone
    settle();
    load_setting({4{16'h2000}}, {4{16'hE000}}, 4'd0, rvf_pkg::PASS_FINAL, 16'hFFFF);
    send_column(flat_column(12'd7, 16'hFFFF));
    cols_ch.valid <= 1'b0;

    // random phases, each with its own idling style on both sides
    pick = items_sent;
    while (items_sent < pick + RANDOM_ITEMS) begin
      settle();
      src_steady  = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: run_single_batch();
        9: run_broken_sequence();
        default: run_wide_filter();
      endcase
    end

    // drain: everything back, then a further wait for stray pixels
    sink_steady = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d columns under %0d register settings", sb.n_columns, n_settings);
    $display("checked %0d pixels, %0d partial sum stores", sb.n_pixels, sb.n_stored);
    if (sb.errors == 0)
      $display("resize_vertical_u16_fir_accum regression: pass");
    else
      $display("resize_vertical_u16_fir_accum regression: fail");
    $finish;
  end

endmodule
